/* hw/rtl/ssca_pkg.sv */
// Shared types and constants for the sticky slot color allocator.
package ssca_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int COLORS_DEF = 16;
    localparam int ID_W       = 31;
    localparam int OUT_W      = 4;

    typedef enum logic [1:0] {
        CMD_RESET   = 2'd0,
        CMD_ROUND   = 2'd1,
        CMD_RESERVE = 2'd2,
        CMD_CLAIM   = 2'd3
    } t_cmd;

    typedef struct packed {
        logic load;
        logic exec;
        logic reserve;
        logic pick;
        logic commit;
    } t_dp_cmd;

endpackage

/* hw/rtl/ssca_dp.sv */
// Datapath of the allocator: slot table, scan vectors, color search and result registers.
module ssca_dp
    import ssca_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int COLORS = COLORS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_dp_cmd          i_ctrl,
    output t_cmd             o_cmd,
    input  t_cmd             i_cmd,
    input  logic [ID_W-1:0]  i_client_id,
    output logic [OUT_W-1:0] o_slot_index,
    output logic [OUT_W-1:0] o_color_index,
    output logic             o_was_present,
    output logic             o_claim_ok
);

    localparam int SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW     = $clog2(SLOTS + 1);
    localparam int KW     = $clog2(COLORS);
    localparam int WSW    = $clog2(ID_W * (COLORS - 1) + 1);
    localparam int RSTEPS = $clog2(ID_W + 1);

    function automatic logic [KW-1:0] pow2_mod(input int j);
        int w;
        w = 1;
        for (int k = 0; k < j; k++) begin
            w = w * 2;
            if (w >= COLORS) begin
                w = w - COLORS;
            end
        end
        return KW'(w);
    endfunction

    logic [ID_W-1:0]   r_client [SLOTS];
    logic [KW-1:0]     r_color  [SLOTS];
    logic [SLOTS-1:0]  r_active;
    logic [CW-1:0]     r_count;

    t_cmd              r_cmd;
    logic [ID_W-1:0]   r_id;
    logic [WSW-1:0]    r_wsum;
    logic [SLOTS-1:0]  r_match;
    logic [SLOTS-1:0]  r_inact;
    logic [COLORS-1:0] r_used;
    logic [KW-1:0]     r_base;
    logic              r_hit;
    logic [SW-1:0]     r_hit_idx;
    logic              r_free_v;
    logic [SW-1:0]     r_free_idx;
    logic [KW-1:0]     r_newcolor;
    logic [OUT_W-1:0]  r_slot_index;
    logic [OUT_W-1:0]  r_color_index;
    logic              r_was_present;
    logic              r_claim_ok;

    logic [WSW-1:0]    n_wsum;
    logic [SLOTS-1:0]  n_match;
    logic [SLOTS-1:0]  n_inact;
    logic [COLORS-1:0] n_used;
    logic [KW-1:0]     n_base;
    logic              n_hit;
    logic [SW-1:0]     n_hit_idx;
    logic              n_free_v;
    logic [SW-1:0]     n_free_idx;
    logic [KW-1:0]     n_newcolor;
    logic [OUT_W-1:0]  n_slot_index;
    logic [OUT_W-1:0]  n_color_index;
    logic              n_was_present;
    logic              n_claim_ok;
    logic              wr_en;
    logic              grow;
    logic [SW-1:0]     wr_idx;
    logic [SLOTS-1:0]  in_use;

    // The residue of the ID is formed as a weighted sum of its bits, then reduced.
    always_comb begin
        n_wsum = '0;
        for (int j = 0; j < ID_W; j++) begin
            if (i_client_id[j]) begin
                n_wsum = n_wsum + WSW'(pow2_mod(j));
            end
        end
    end

    always_comb begin
        logic [WSW:0] red;
        red = {1'b0, r_wsum};
        for (int k = RSTEPS - 1; k >= 0; k--) begin
            if (red >= (WSW + 1)'(COLORS << k)) begin
                red = red - (WSW + 1)'(COLORS << k);
            end
        end
        n_base = red[KW-1:0];
    end

    always_comb begin
        n_used = '0;
        for (int i = 0; i < SLOTS; i++) begin
            in_use[i]  = (CW'(i) < r_count);
            n_match[i] = in_use[i] && (r_client[i] == r_id);
            n_inact[i] = in_use[i] && !r_active[i];
            if (in_use[i] && r_active[i]) begin
                n_used[r_color[i]] = 1'b1;
            end
        end
    end

    always_comb begin
        n_hit      = 1'b0;
        n_hit_idx  = '0;
        n_free_v   = 1'b0;
        n_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                n_hit     = 1'b1;
                n_hit_idx = SW'(i);
            end
            if (r_inact[i]) begin
                n_free_v   = 1'b1;
                n_free_idx = SW'(i);
            end
        end
    end

    always_comb begin
        logic [KW:0] cand;
        logic        found;
        n_newcolor = r_base;
        found      = 1'b0;
        for (int c = 0; c < COLORS; c++) begin
            cand = {1'b0, r_base} + (KW + 1)'(c);
            if (cand >= (KW + 1)'(COLORS)) begin
                cand = cand - (KW + 1)'(COLORS);
            end
            if (!found && !r_used[cand[KW-1:0]]) begin
                n_newcolor = cand[KW-1:0];
                found      = 1'b1;
            end
        end
    end

    always_comb begin
        logic [SW+OUT_W-1:0] slot_ext;
        logic [KW+OUT_W-1:0] color_ext;
        wr_en         = 1'b0;
        grow          = 1'b0;
        wr_idx        = '0;
        slot_ext      = '0;
        color_ext     = '0;
        n_was_present = 1'b0;
        n_claim_ok    = 1'b0;
        if (r_hit) begin
            slot_ext      = {{OUT_W{1'b0}}, r_hit_idx};
            color_ext     = {{OUT_W{1'b0}}, r_color[r_hit_idx]};
            n_was_present = 1'b1;
            n_claim_ok    = 1'b1;
        end else begin
            if (r_free_v) begin
                wr_en  = 1'b1;
                wr_idx = r_free_idx;
            end else if (r_count < CW'(SLOTS)) begin
                wr_en  = 1'b1;
                grow   = 1'b1;
                wr_idx = r_count[SW-1:0];
            end
            if (wr_en) begin
                slot_ext   = {{OUT_W{1'b0}}, wr_idx};
                color_ext  = {{OUT_W{1'b0}}, r_newcolor};
                n_claim_ok = 1'b1;
            end
        end
        n_slot_index  = slot_ext[OUT_W-1:0];
        n_color_index = color_ext[OUT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.exec && r_cmd == CMD_RESET) begin
            r_count <= '0;
        end else if (i_ctrl.commit && grow) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_cmd  <= i_cmd;
            r_id   <= i_client_id;
            r_wsum <= n_wsum;
        end
        if (i_ctrl.exec) begin
            r_match <= n_match;
            r_inact <= n_inact;
            r_used  <= n_used;
            r_base  <= n_base;
        end
        if (i_ctrl.pick) begin
            r_hit      <= n_hit;
            r_hit_idx  <= n_hit_idx;
            r_free_v   <= n_free_v;
            r_free_idx <= n_free_idx;
            r_newcolor <= n_newcolor;
        end
        if (i_ctrl.commit) begin
            r_slot_index  <= n_slot_index;
            r_color_index <= n_color_index;
            r_was_present <= n_was_present;
            r_claim_ok    <= n_claim_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS; i++) begin
            if (i_ctrl.exec && r_cmd == CMD_ROUND && in_use[i]) begin
                r_active[i] <= 1'b0;
            end else if (i_ctrl.reserve && r_match[i]) begin
                r_active[i] <= 1'b1;
            end else if (i_ctrl.commit && wr_en && wr_idx == SW'(i)) begin
                r_active[i] <= 1'b1;
                r_client[i] <= r_id;
                r_color[i]  <= r_newcolor;
            end
        end
    end

    assign o_cmd         = r_cmd;
    assign o_slot_index  = r_slot_index;
    assign o_color_index = r_color_index;
    assign o_was_present = r_was_present;
    assign o_claim_ok    = r_claim_ok;

endmodule

/* hw/rtl/ssca_ctrl.sv */
// Controller state machine of the allocator: sequences each command through the datapath.
module ssca_ctrl
    import ssca_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_status,
    output t_dp_cmd o_ctrl,
    output logic    o_valid
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RESV,
        S_PICK,
        S_WRITE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_WRITE);
        end
    end

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_ctrl.load = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctrl.exec = 1'b1;
                unique case (i_status) inside
                    CMD_CLAIM:            n_state = S_PICK;
                    CMD_RESERVE:          n_state = S_RESV;
                    CMD_RESET, CMD_ROUND: n_state = S_IDLE;
                    default:              n_state = S_IDLE;
                endcase
            end
            S_RESV: begin
                o_ctrl.reserve = 1'b1;
                n_state        = S_IDLE;
            end
            S_PICK: begin
                o_ctrl.pick = 1'b1;
                n_state     = S_WRITE;
            end
            S_WRITE: begin
                o_ctrl.commit = 1'b1;
                n_state       = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_valid;

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> r_state == S_EXEC)
        else $error("accepted command did not enter the execute step");

    a_pick_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PICK |=> r_state == S_WRITE)
        else $error("claim selection was not followed by the table write");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !busy)
        else $error("result strobe raised while a command is in progress");

    a_resv_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RESV |-> i_status == CMD_RESERVE)
        else $error("reserve step entered for another command");

endmodule

/* hw/rtl/sticky_slot_color_allocator.sv */
// Top level of the sticky slot color allocator: controller and datapath.
// A command transfer happens when start is high while busy is low, and busy then stays high
// until the command is through its last step. The controller walks each command through a
// table compare step; reset table and begin round end there, a reserve adds a reserve mark
// step, and a claim adds a priority select and color search step and a table write step.
// Only a claim gives a result: o_valid is high for exactly one cycle, the cycle right after
// the claim completes, and the result fields are valid with it. The receiver cannot hold a
// result off, so it must take every result in that cycle.
module sticky_slot_color_allocator
    import ssca_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int COLORS = COLORS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       i_cmd,
    input  logic [ID_W-1:0]  i_client_id,
    output logic             o_valid,
    output logic [OUT_W-1:0] o_slot_index,
    output logic [OUT_W-1:0] o_color_index,
    output logic             o_was_present,
    output logic             o_claim_ok
);

    t_dp_cmd ctrl;
    t_cmd    status;

    ssca_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (status),
        .o_ctrl   (ctrl),
        .o_valid  (o_valid)
    );

    ssca_dp #(
        .SLOTS  (SLOTS),
        .COLORS (COLORS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .o_cmd         (status),
        .i_cmd         (t_cmd'(i_cmd)),
        .i_client_id   (i_client_id),
        .o_slot_index  (o_slot_index),
        .o_color_index (o_color_index),
        .o_was_present (o_was_present),
        .o_claim_ok    (o_claim_ok)
    );

endmodule

/* tb/sv/sticky_slot_color_allocator_tb.sv */
// Self-checking testbench for the sticky slot color allocator: directed table, random episodes.
module sticky_slot_color_allocator_tb;
    import ssca_pkg::*;

    localparam int WATCHDOG_LIMIT = 400;
    localparam int TARGET_CMDS    = 1050;
    localparam int TAIL_CYCLES    = 8;

    typedef struct packed {
        logic [OUT_W-1:0] slot;
        logic [OUT_W-1:0] color;
        logic             present;
        logic             ok;
    } t_claim_res;

    typedef struct packed {
        t_cmd            op;
        logic [ID_W-1:0] id;
        logic [7:0]      reps;
        logic            typed;
        t_claim_res      want;
    } t_script_row;

    localparam int SCRIPT_LEN = 26;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic            busy;
    logic [1:0]      i_cmd;
    logic [ID_W-1:0] i_client_id;
    logic            o_valid;
    logic [OUT_W-1:0] o_slot_index;
    logic [OUT_W-1:0] o_color_index;
    logic            o_was_present;
    logic            o_claim_ok;

    // Predicted copy of the slot table.
    logic [ID_W-1:0] tbl_client [SLOTS_DEF];
    logic [3:0]      tbl_color  [SLOTS_DEF];
    bit              tbl_active [SLOTS_DEF];
    int              tbl_count;

    t_claim_res pending_claims [$];
    t_claim_res last_got;
    t_claim_res want_res;

    int n_errors;
    int n_sent;
    int n_claims;
    int n_full;
    int n_checked;
    int idle_cycles;
    bit took_cmd;

    t_script_row script [SCRIPT_LEN];

    sticky_slot_color_allocator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_client_id   (i_client_id),
        .o_valid       (o_valid),
        .o_slot_index  (o_slot_index),
        .o_color_index (o_color_index),
        .o_was_present (o_was_present),
        .o_claim_ok    (o_claim_ok)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    function automatic void check_result(t_claim_res want, t_claim_res got);
        check_field("slot_index", 32'(want.slot), 32'(got.slot));
        check_field("color_index", 32'(want.color), 32'(got.color));
        check_field("was_present", 32'(want.present), 32'(got.present));
        check_field("claim_ok", 32'(want.ok), 32'(got.ok));
    endfunction

    // Applies one accepted command to the predicted table and queues the claim outcome.
    function automatic void apply_command(t_cmd op, logic [ID_W-1:0] id);
        int k;
        int pick;
        int cand;
        int chosen;
        bit done;
        bit color_found;
        logic [COLORS_DEF-1:0] used;
        t_claim_res r;
        case (op)
            CMD_RESET: begin
                tbl_count = 0;
            end
            CMD_ROUND: begin
                for (k = 0; k < tbl_count; k++) tbl_active[k] = 1'b0;
            end
            CMD_RESERVE: begin
                for (k = 0; k < tbl_count; k++)
                    if (tbl_client[k] == id) tbl_active[k] = 1'b1;
            end
            default: begin
                used = '0;
                pick = -1;
                done = 1'b0;
                r = '0;
                for (k = 0; k < tbl_count; k++) begin
                    if (!done) begin
                        if (tbl_client[k] == id) begin
                            r = '{slot: k[3:0], color: tbl_color[k], present: 1'b1, ok: 1'b1};
                            done = 1'b1;
                        end else if (tbl_active[k]) begin
                            used[tbl_color[k]] = 1'b1;
                        end else if (pick < 0) begin
                            pick = k;
                        end
                    end
                end
                if (!done && pick < 0) begin
                    if (tbl_count >= SLOTS_DEF) begin
                        r = '0;
                        n_full++;
                        done = 1'b1;
                    end else begin
                        pick = tbl_count;
                        tbl_count++;
                    end
                end
                if (!done) begin
                    chosen = int'(id % COLORS_DEF);
                    color_found = 1'b0;
                    for (k = 0; k < COLORS_DEF; k++) begin
                        cand = (int'(id % COLORS_DEF) + k) % COLORS_DEF;
                        if (!color_found && !used[cand]) begin
                            chosen = cand;
                            color_found = 1'b1;
                        end
                    end
                    tbl_client[pick] = id;
                    tbl_color[pick] = chosen[3:0];
                    tbl_active[pick] = 1'b1;
                    r = '{slot: pick[3:0], color: chosen[3:0], present: 1'b0, ok: 1'b1};
                end
                pending_claims.push_back(r);
                n_claims++;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid === 1'b1) begin
                last_got = '{slot: o_slot_index, color: o_color_index,
                             present: o_was_present, ok: o_claim_ok};
                if (pending_claims.size() == 0) begin
                    $error("result transfer with no claim outstanding");
                    n_errors++;
                end else begin
                    want_res = pending_claims.pop_front();
                    check_result(want_res, last_got);
                end
                n_checked++;
            end
            took_cmd = (start && busy === 1'b0);
            if (took_cmd) apply_command(t_cmd'(i_cmd), i_client_id);
            if (took_cmd || o_valid === 1'b1) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
                $display("sticky_slot_color_allocator_tb: done, errors");
                $finish;
            end
        end
    end

    // Holds the command until the block takes it, then leaves start high.
    task automatic send_cmd(t_cmd op, logic [ID_W-1:0] id);
        start = 1'b1;
        i_cmd = op;
        i_client_id = id;
        do @(posedge i_clk); while (busy !== 1'b0);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle(int cycles);
        if (cycles > 0) begin
            start = 1'b0;
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    task automatic wait_drain();
        start = 1'b0;
        while (pending_claims.size() != 0 || busy !== 1'b0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    function automatic logic [ID_W-1:0] fresh_id();
        logic [ID_W-1:0] v;
        v = ID_W'($urandom);
        if (v == '0) v = 1;
        return v;
    endfunction

    initial begin
        int r;
        int k;
        int pool_size;
        int ep_len;
        int round_w;
        int reset_w;
        int roll;
        int burst_left;
        bit quiet;
        t_cmd op;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] pool [24];

        script = '{
            '{CMD_CLAIM,   31'd1,          8'd1,  1'b1, '{4'd0,  4'd1,  1'b0, 1'b1}},
            '{CMD_CLAIM,   31'h7FFFFFFF,   8'd1,  1'b1, '{4'd1,  4'd15, 1'b0, 1'b1}},
            '{CMD_CLAIM,   31'd1,          8'd1,  1'b1, '{4'd0,  4'd1,  1'b1, 1'b1}},
            '{CMD_CLAIM,   31'd17,         8'd1,  1'b0, '0},
            '{CMD_RESERVE, 31'd99,         8'd1,  1'b0, '0},
            '{CMD_ROUND,   31'd1,          8'd1,  1'b0, '0},
            '{CMD_RESERVE, 31'd1,          8'd1,  1'b0, '0},
            '{CMD_CLAIM,   31'd33,         8'd1,  1'b0, '0},
            '{CMD_CLAIM,   31'd17,         8'd1,  1'b0, '0},
            '{CMD_CLAIM,   31'h2AAAAAAA,   8'd1,  1'b0, '0},
            '{CMD_CLAIM,   31'h55555555,   8'd1,  1'b0, '0},
            '{CMD_RESET,   31'd1,          8'd1,  1'b0, '0},
            '{CMD_CLAIM,   31'd5,          8'd1,  1'b1, '{4'd0,  4'd5,  1'b0, 1'b1}},
            '{CMD_CLAIM,   31'd6,          8'd15, 1'b0, '0},
            '{CMD_CLAIM,   31'h40000000,   8'd1,  1'b1, '{4'd0,  4'd0,  1'b0, 1'b0}},
            '{CMD_CLAIM,   31'd20,         8'd1,  1'b1, '{4'd15, 4'd4,  1'b1, 1'b1}},
            '{CMD_RESERVE, 31'h7FFFFFFF,   8'd1,  1'b0, '0},
            '{CMD_CLAIM,   31'h7FFFFFFF,   8'd1,  1'b1, '{4'd0,  4'd0,  1'b0, 1'b0}},
            '{CMD_ROUND,   31'd1,          8'd1,  1'b0, '0},
            '{CMD_RESERVE, 31'd5,          8'd1,  1'b0, '0},
            '{CMD_RESERVE, 31'd10,         8'd1,  1'b0, '0},
            '{CMD_CLAIM,   31'h7FFFFFFF,   8'd1,  1'b0, '0},
            '{CMD_RESET,   31'd1,          8'd1,  1'b0, '0},
            '{CMD_RESERVE, 31'd5,          8'd1,  1'b0, '0},
            '{CMD_ROUND,   31'd1,          8'd1,  1'b0, '0},
            '{CMD_CLAIM,   31'h3FFFFFFF,   8'd1,  1'b1, '{4'd0,  4'd15, 1'b0, 1'b1}}
        };

        n_errors = 0;
        n_sent = 0;
        n_claims = 0;
        n_full = 0;
        n_checked = 0;
        idle_cycles = 0;
        tbl_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = CMD_RESET;
        i_client_id = 1;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (r = 0; r < SCRIPT_LEN; r++) begin
            for (k = 0; k < int'(script[r].reps); k++)
                send_cmd(script[r].op, script[r].id + ID_W'(k));
            if (script[r].typed) begin
                wait_drain();
                check_result(script[r].want, last_got);
            end
        end
        wait_drain();

        burst_left = $urandom_range(1, 12);
        while (n_sent < TARGET_CMDS) begin
            pool_size = $urandom_range(6, 24);
            for (k = 0; k < pool_size; k++) pool[k] = fresh_id();
            ep_len = $urandom_range(20, 80);
            round_w = $urandom_range(1, 20);
            reset_w = $urandom_range(0, 4);
            quiet = ($urandom_range(0, 3) == 0);
            for (k = 0; k < ep_len; k++) begin
                roll = $urandom_range(0, 99);
                if (roll < reset_w) op = CMD_RESET;
                else if (roll < reset_w + round_w) op = CMD_ROUND;
                else if (roll < reset_w + round_w + 20) op = CMD_RESERVE;
                else op = CMD_CLAIM;
                if ($urandom_range(0, 9) < 8) id = pool[$urandom_range(0, pool_size - 1)];
                else id = fresh_id();
                send_cmd(op, id);
                if (!quiet) begin
                    burst_left = burst_left - 1;
                    if (burst_left == 0) begin
                        idle($urandom_range(1, 8));
                        burst_left = $urandom_range(1, 12);
                    end
                end
            end
            if ($urandom_range(0, 3) == 0) wait_drain();
        end

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_claims.size() != 0) begin
            $error("%0d claim results never arrived", pending_claims.size());
            n_errors++;
        end
        $display("Sent %0d commands, %0d of them claims; %0d claims found the table full.",
                 n_sent, n_claims, n_full);
        $display("Checked %0d result transfers against the predicted table.", n_checked);
        if (n_errors == 0) begin
            $display("sticky_slot_color_allocator_tb: done, clean");
        end else begin
            $display("sticky_slot_color_allocator_tb: done, errors");
        end
        $finish;
    end

endmodule
